### src/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted store with binary search:
// item mode codes, read address selects and the controller/datapath buses.
// ----------------------------------------------------------------------------
package stbs_pkg;

    // default store depth
    localparam int STBS_MAX_ITEMS = 16;

    // widths of the result fields
    localparam int POS_W   = 4;
    localparam int PROBE_W = 3;

    // item mode codes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // read address select for the store
    typedef enum logic [1:0] {
        ADDR_I,
        ADDR_J,
        ADDR_JN,
        ADDR_MID
    } t_addr_sel;

    // commands from the controller to the datapath
    typedef struct packed {
        logic      load;
        logic      clear;
        logic      search_start;
        logic      row_start;
        logic      load_vi;
        logic      cmp_step;
        logic      write_i;
        logic      set_sorted;
        logic      probe;
        logic      probe_cmp;
        logic      emit;
        t_addr_sel addr_sel;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic sorted;
        logic rows_done;
        logic j_last;
        logic range_empty;
        logic key_eq;
        logic out_free;
    } t_status;

endpackage

### src/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for the sorted store: decodes requests, steps the exchange sort
// row by row, runs the probe loop of the binary search, hands off results.
// ----------------------------------------------------------------------------
module stbs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_mode,
    input  stbs_pkg::t_status i_status,
    output logic              o_in_stall,
    output stbs_pkg::t_cmd    o_cmd
);
    import stbs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT_RD_I,
        S_SORT_LD_I,
        S_SORT_CMP,
        S_SORT_WR_I,
        S_PROBE,
        S_PROBE_CMP,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_mode)
                        MODE_LOAD: begin
                            o_cmd.load = 1'b1;
                            n_state    = S_EMIT;
                        end
                        MODE_SEARCH: begin
                            o_cmd.search_start = 1'b1;
                            n_state = i_status.sorted ? S_PROBE : S_SORT_RD_I;
                        end
                        MODE_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SORT_RD_I: begin
                if (i_status.rows_done) begin
                    o_cmd.set_sorted = 1'b1;
                    n_state          = S_PROBE;
                end else begin
                    o_cmd.addr_sel  = ADDR_I;
                    o_cmd.row_start = 1'b1;
                    n_state         = S_SORT_LD_I;
                end
            end
            S_SORT_LD_I: begin
                o_cmd.load_vi  = 1'b1;
                o_cmd.addr_sel = ADDR_J;
                n_state        = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                o_cmd.cmp_step = 1'b1;
                o_cmd.addr_sel = ADDR_JN;
                if (i_status.j_last) begin
                    n_state = S_SORT_WR_I;
                end
            end
            S_SORT_WR_I: begin
                o_cmd.write_i = 1'b1;
                n_state       = S_SORT_RD_I;
            end
            S_PROBE: begin
                if (i_status.range_empty) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.probe    = 1'b1;
                    o_cmd.addr_sel = ADDR_MID;
                    n_state        = S_PROBE_CMP;
                end
            end
            S_PROBE_CMP: begin
                o_cmd.probe_cmp = 1'b1;
                n_state = i_status.key_eq ? S_EMIT : S_PROBE;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/stbs_dp.sv
// ----------------------------------------------------------------------------
// stbs_dp
// Datapath of the sorted store: value memory with registered read, sort
// indexes and running minimum, search bounds, result and output registers.
// ----------------------------------------------------------------------------
module stbs_dp #(
    parameter int MAX_ITEMS = stbs_pkg::STBS_MAX_ITEMS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stbs_pkg::t_cmd                i_cmd,
    input  logic signed [31:0]            i_value,
    input  logic                          i_out_stall,
    output stbs_pkg::t_status             o_status,
    output logic                          o_out_valid,
    output logic                          o_found,
    output logic [stbs_pkg::POS_W-1:0]    o_position,
    output logic [stbs_pkg::PROBE_W-1:0]  o_probes,
    output logic                          o_dropped
);
    import stbs_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ITEMS);

    // value store
    logic signed [31:0] r_mem [MAX_ITEMS];
    logic signed [31:0] r_rdata;

    // control state
    logic [CW-1:0] r_fill;
    logic          r_sorted;
    logic          r_full_seen;
    logic          r_out_valid;

    // working registers
    logic [AW-1:0]        r_i;
    logic [AW-1:0]        r_j;
    logic signed [31:0]   r_vi;
    logic signed [31:0]   r_key;
    logic [CW-1:0]        r_lo;
    logic [CW-1:0]        r_hi;
    logic [AW-1:0]        r_mid;
    logic [PROBE_W-1:0]   r_count;
    logic                 r_hit;
    logic                 r_drop;
    logic                 r_found_q;
    logic [POS_W-1:0]     r_pos_q;
    logic [PROBE_W-1:0]   r_probes_q;
    logic                 r_drop_q;

    logic                 full;
    logic [CW-1:0]        mid_full;
    logic [AW-1:0]        mid;
    logic [AW-1:0]        rd_addr;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic signed [31:0]   wdata;
    logic                 swap;
    logic [AW+POS_W-1:0]  mid_ext;

    assign full     = (r_fill == FULL_COUNT);
    assign mid_full = r_lo + ((r_hi - r_lo) >> 1);
    assign mid      = mid_full[AW-1:0];
    assign swap     = (r_rdata < r_vi);
    assign mid_ext  = {{POS_W{1'b0}}, r_mid};

    // status to the controller
    assign o_status.sorted      = r_sorted;
    assign o_status.rows_done   = (CW'(r_i) + CW'(1)) >= r_fill;
    assign o_status.j_last      = (CW'(r_j) + CW'(1)) == r_fill;
    assign o_status.range_empty = !(r_lo < r_hi);
    assign o_status.key_eq      = (r_rdata == r_key);
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

    // read address select
    always_comb begin
        case (i_cmd.addr_sel)
            ADDR_I:   rd_addr = r_i;
            ADDR_J:   rd_addr = r_j;
            ADDR_JN:  rd_addr = r_j + AW'(1);
            ADDR_MID: rd_addr = mid;
            default:  rd_addr = r_i;
        endcase
    end

    // single write port
    always_comb begin
        we    = 1'b0;
        waddr = r_i;
        wdata = r_vi;
        if (i_cmd.load && !full) begin
            we    = 1'b1;
            waddr = r_fill[AW-1:0];
            wdata = i_value;
        end else if (i_cmd.cmp_step && swap) begin
            we    = 1'b1;
            waddr = r_j;
            wdata = r_vi;
        end else if (i_cmd.write_i) begin
            we    = 1'b1;
            waddr = r_i;
            wdata = r_vi;
        end
    end

    // memory with registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // fill count and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_sorted    <= 1'b0;
            r_full_seen <= 1'b0;
        end else if (i_cmd.clear) begin
            r_fill      <= '0;
            r_sorted    <= 1'b0;
            r_full_seen <= 1'b0;
        end else if (i_cmd.load) begin
            if (full) begin
                r_full_seen <= 1'b1;
            end else begin
                r_fill   <= r_fill + CW'(1);
                r_sorted <= 1'b0;
            end
        end else if (i_cmd.set_sorted) begin
            r_sorted <= 1'b1;
        end
    end

    // sort indexes and running minimum of the row
    always_ff @(posedge i_clk) begin
        if (i_cmd.search_start) begin
            r_i <= '0;
        end else if (i_cmd.write_i) begin
            r_i <= r_i + AW'(1);
        end
        if (i_cmd.row_start) begin
            r_j <= r_i + AW'(1);
        end else if (i_cmd.cmp_step) begin
            r_j <= r_j + AW'(1);
        end
        if (i_cmd.load_vi) begin
            r_vi <= r_rdata;
        end else if (i_cmd.cmp_step && swap) begin
            r_vi <= r_rdata;
        end
    end

    // search bounds and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit   <= 1'b0;
            r_mid   <= '0;
            r_count <= '0;
            r_drop  <= full;
        end else if (i_cmd.search_start) begin
            r_key   <= i_value;
            r_lo    <= '0;
            r_hi    <= r_fill;
            r_hit   <= 1'b0;
            r_mid   <= '0;
            r_count <= '0;
            r_drop  <= r_full_seen;
        end else if (i_cmd.probe) begin
            r_mid   <= mid;
            r_count <= r_count + PROBE_W'(1);
        end else if (i_cmd.probe_cmp) begin
            if (r_rdata == r_key) begin
                r_hit <= 1'b1;
            end else if (r_key < r_rdata) begin
                r_hi <= CW'(r_mid);
            end else begin
                r_lo <= CW'(r_mid) + CW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_found_q  <= r_hit;
            r_pos_q    <= mid_ext[POS_W-1:0];
            r_probes_q <= r_count;
            r_drop_q   <= r_drop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found_q;
    assign o_position  = r_pos_q;
    assign o_probes    = r_probes_q;
    assign o_dropped   = r_drop_q;

endmodule

### src/sort_then_binary_search.sv
// ----------------------------------------------------------------------------
// sort_then_binary_search
// Store of signed 32-bit values with a lazy exchange sort and binary search.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with i_mode and i_value. A request
// is taken when valid is high and stall is low. Mode load appends i_value
// (refused when the store is full), mode search looks up the key i_value,
// mode clear empties the store, the unused code is ignored.
// Output channel: o_out_valid / i_out_stall with o_found, o_position,
// o_probes and o_dropped. Load and search give one result, clear none.
// A load goes to the hand-off state and its result is then registered in
// the output register. A search on a sorted store runs a probe state and a
// compare state for each probe, then the hand-off state. The first search
// after a load that stored a value runs the exchange sort first: per row a
// read, a load and a write state, plus a compare state per compare. The
// single write port and registered read of the store set this sequence.
// One request is worked at a time; the next one is taken while the last
// result still waits in the output register. A stalled result holds and
// the block waits in its hand-off state until the register frees.
// Reset empties the store and clears the flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sort_then_binary_search #(
    parameter int MAX_ITEMS = stbs_pkg::STBS_MAX_ITEMS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_mode,
    input  logic signed [31:0]            i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [stbs_pkg::POS_W-1:0]    o_position,
    output logic [stbs_pkg::PROBE_W-1:0]  o_probes,
    output logic                          o_dropped
);
    import stbs_pkg::*;

    t_cmd    cmd;
    t_status status;

    // controller
    stbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // datapath
    stbs_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_found     (o_found),
        .o_position  (o_position),
        .o_probes    (o_probes),
        .o_dropped   (o_dropped)
    );

endmodule

### src/stbs_chk.sv
// ----------------------------------------------------------------------------
// stbs_chk
// Port-level checks for the sorted store, bound to the top level.
// ----------------------------------------------------------------------------
module stbs_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [1:0]                    i_mode,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_found,
    input logic [stbs_pkg::POS_W-1:0]    o_position,
    input logic [stbs_pkg::PROBE_W-1:0]  o_probes,
    input logic                          o_dropped
);
    import stbs_pkg::*;

    logic in_take;

    assign in_take = i_in_valid && !o_in_stall;

    // a load request always yields a result, so the block goes busy
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && (i_mode == MODE_LOAD) |=> o_in_stall)
        else $error("load request did not start a result hand-off");

    // a clear request gives no result and leaves the block ready
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && (i_mode == MODE_CLEAR) |=> !o_in_stall)
        else $error("clear request left the block busy");

    // a stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its fields
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_found) && $stable(o_position)
            && $stable(o_probes) && $stable(o_dropped))
        else $error("result fields changed while stalled");

endmodule

bind sort_then_binary_search stbs_chk u_stbs_chk (.*);
